// ===== design/lbts_pkg.sv =====
// shared widths, codes and reset values of the landing burn throttle sequencer
package lbts_pkg;

    localparam int THR_FRAC_DEF = 16;

    localparam int MASS_W   = 24;
    localparam int HS_W     = 20;
    localparam int VS_W     = 21;
    localparam int TS_W     = 20;
    localparam int ALT_W    = 31;
    localparam int THRUST_W = 32;
    localparam int GRAV_W   = 17;
    localparam int SPD_W    = 17;
    localparam int MARGIN_W = 27;
    localparam int DEN_W    = 42;  // thrust times 1000
    localparam int VMAG_W   = 21;
    localparam int PROD_W   = 2 * VMAG_W;
    localparam int NUM5_W   = PROD_W + 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [ALT_W-1:0] HEIGHT_MAX = '1;

    localparam logic [THRUST_W-1:0] RST_THRUST = '0;
    localparam logic [GRAV_W-1:0]   RST_GRAV   = GRAV_W'(9810);
    localparam logic [SPD_W-1:0]    RST_FINAL  = SPD_W'(500);
    localparam logic [SPD_W-1:0]    RST_HLIM   = SPD_W'(1000);
    localparam logic [MARGIN_W-1:0] RST_COAST  = MARGIN_W'(200000);
    localparam logic [MARGIN_W-1:0] RST_BURN   = MARGIN_W'(2000);
    localparam logic [SPD_W-1:0]    RST_TOUCH  = SPD_W'(500);

    typedef enum logic [2:0] {
        REG_THRUST = 3'd0,
        REG_GRAV   = 3'd1,
        REG_FINAL  = 3'd2,
        REG_HLIM   = 3'd3,
        REG_COAST  = 3'd4,
        REG_BURN   = 3'd5,
        REG_TOUCH  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_HKILL  = 2'd0,
        PH_BURN   = 2'd1,
        PH_FINAL  = 2'd2,
        PH_LANDED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        FLT_NONE      = 2'd0,
        FLT_NO_THRUST = 2'd1,
        FLT_WEAK      = 2'd2
    } t_fault;

endpackage

// ===== design/lbts_mul.sv =====
// bit-serial shift-add squarer
module lbts_mul #(
    parameter int W     = lbts_pkg::VMAG_W,
    parameter int CNT_W = $clog2(W + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    output logic           o_done,
    output logic [2*W-1:0] o_prod
);
    logic [2*W-1:0]   r_mcand, r_acc;
    logic [W-1:0]     r_mplier;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= {{W{1'b0}}, i_a};
            r_mplier <= i_a;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== design/lbts_div.sv =====
// restoring divider, one quotient bit per cycle
module lbts_div #(
    parameter int NUM_W  = lbts_pkg::GRAV_W + lbts_pkg::MASS_W + lbts_pkg::THR_FRAC_DEF,
    parameter int DIV_W  = lbts_pkg::DEN_W,
    parameter int STEP_W = $clog2(NUM_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,   // left aligned dividend
    input  logic [DIV_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quot
);
    logic [NUM_W-1:0]  r_num, r_quot;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DIV_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem[DIV_W-1:0], r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== design/landing_burn_throttle_sequencer_top.sv =====
// landing burn throttle sequencer: telemetry in, one throttle decision out
//
// s_axis carries one telemetry sample per request, m_axis one throttle decision
// per sample. configuration goes through the apb port (pready always high,
// register i at byte address 4*i); the user must see that it is written only
// while the block is idle, which the block itself does not enforce. one sample
// is worked at a time. a latched fault, a landed vessel or a zero thrust skips
// the arithmetic; else the divider first forms thrust/mass, after which a phase
// exit ends the work, a stopping-height test in phase one or two runs the
// bit-serial squarer of the speed and the divider again, and a final phase
// hover throttle below full scale runs the divider again. the serial restoring
// divider, one quotient bit per cycle, is shared by all three divisions.
// the result sits in an output register; the next sample is accepted while it
// waits, and a stalled receiver only holds the block at its last step.
// reset (synchronous, active low) returns to the horizontal kill phase, clears
// the fault latch and loads the register defaults.
module landing_burn_throttle_sequencer_top #(
    parameter int THROTTLE_FRAC_BITS = lbts_pkg::THR_FRAC_DEF,
    parameter int THR_W  = THROTTLE_FRAC_BITS + 1,
    parameter int IN_W   = 116 + THR_W,
    parameter int IN_BW  = ((IN_W + 7) / 8) * 8,
    parameter int OUT_W  = THR_W + 6,
    parameter int OUT_BW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbts_pkg::ADDR_W-1:0] paddr,
    input  logic [lbts_pkg::DATA_W-1:0] pwdata,
    output logic [lbts_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // samples in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // vessel_mass, horizontal_speed, vertical_speed, total_speed, altitude,
    // current_throttle
    input  logic [IN_BW-1:0]            s_axis_tdata,
    // decisions out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // throttle_cmd, throttle_write, gear_down, landing_phase, status_code
    output logic [OUT_BW-1:0]           m_axis_tdata
);
    import lbts_pkg::*;

    localparam int F     = THROTTLE_FRAC_BITS;
    localparam int DIV_N = GRAV_W + MASS_W + F;
    localparam int STP_W = $clog2(DIV_N + 1);
    localparam logic [THR_W-1:0] THR_FULL = THR_W'(1) << F;

    // field offsets in tdata
    localparam int O_HS  = MASS_W;
    localparam int O_VS  = O_HS + HS_W;
    localparam int O_TS  = O_VS + VS_W;
    localparam int O_ALT = O_TS + TS_W;
    localparam int O_THR = O_ALT + ALT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PRE    = 7'b0000010,
        S_TM     = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_SDIV   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    // configuration registers
    logic [THRUST_W-1:0] r_thrust;
    logic [GRAV_W-1:0]   r_grav;
    logic [SPD_W-1:0]    r_final, r_hlim, r_touch;
    logic [MARGIN_W-1:0] r_coast, r_burn;
    t_reg_idx            reg_idx;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thrust <= RST_THRUST;
            r_grav   <= RST_GRAV;
            r_final  <= RST_FINAL;
            r_hlim   <= RST_HLIM;
            r_coast  <= RST_COAST;
            r_burn   <= RST_BURN;
            r_touch  <= RST_TOUCH;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_THRUST: r_thrust <= pwdata;
                REG_GRAV:   r_grav   <= pwdata[GRAV_W-1:0];
                REG_FINAL:  r_final  <= pwdata[SPD_W-1:0];
                REG_HLIM:   r_hlim   <= pwdata[SPD_W-1:0];
                REG_COAST:  r_coast  <= pwdata[MARGIN_W-1:0];
                REG_BURN:   r_burn   <= pwdata[MARGIN_W-1:0];
                REG_TOUCH:  r_touch  <= pwdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRUST: prdata = r_thrust;
            REG_GRAV:   prdata = DATA_W'(r_grav);
            REG_FINAL:  prdata = DATA_W'(r_final);
            REG_HLIM:   prdata = DATA_W'(r_hlim);
            REG_COAST:  prdata = DATA_W'(r_coast);
            REG_BURN:   prdata = DATA_W'(r_burn);
            REG_TOUCH:  prdata = DATA_W'(r_touch);
            default:    prdata = '0;
        endcase
    end

    // sample registers
    logic [MASS_W-1:0] r_mass;
    logic [HS_W-1:0]   r_hs;
    logic [VMAG_W-1:0] r_vmag;
    logic [TS_W-1:0]   r_ts;
    logic [ALT_W-1:0]  r_alt;
    logic [THR_W-1:0]  r_thr;

    logic [MASS_W-1:0] in_mass;
    logic [VS_W-1:0]   in_vs;
    logic              accept;

    assign in_mass = s_axis_tdata[MASS_W-1:0];
    assign in_vs   = s_axis_tdata[O_VS+VS_W-1:O_VS];

    // state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    t_fault              r_fault, n_fault;
    logic [DEN_W-1:0]    r_accel, n_accel;
    logic [THR_W-1:0]    r_cmd, n_cmd;
    logic                r_wr, n_wr, r_gear, n_gear;
    logic                r_mvalid;
    logic [OUT_BW-1:0]   r_mdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mass <= (in_mass == '0) ? MASS_W'(1) : in_mass;
            r_hs   <= s_axis_tdata[O_HS+HS_W-1:O_HS];
            // magnitude of the descent rate, most negative value included
            r_vmag <= in_vs[VS_W-1] ? (~in_vs + VMAG_W'(1)) : in_vs;
            r_ts   <= s_axis_tdata[O_TS+TS_W-1:O_TS];
            r_alt  <= s_axis_tdata[O_ALT+ALT_W-1:O_ALT];
            r_thr  <= s_axis_tdata[O_THR+THR_W-1:O_THR];
        end
    end

    // shared arithmetic
    logic [DEN_W-1:0]            den_t;
    logic [GRAV_W+MASS_W-1:0]    grav_mass;
    logic [DEN_W-1:0]            tm;
    logic [NUM5_W-1:0]           h_raw;
    logic [ALT_W-1:0]            h_sat;
    logic [ALT_W:0]              h_coast, h_burn;
    logic [PROD_W-1:0]           prod;
    logic [NUM5_W-1:0]           prod5;

    logic              div_start, div_done, mul_start, mul_done;
    logic [DIV_N-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]  div_den;
    logic [STP_W-1:0]  div_steps;
    logic [VMAG_W-1:0] mul_a;

    assign den_t     = {{(DEN_W-THRUST_W){1'b0}}, r_thrust} * DEN_W'(1000);
    assign grav_mass = {{MASS_W{1'b0}}, r_grav} * {{GRAV_W{1'b0}}, r_mass};
    assign tm        = div_quot[DEN_W-1:0];
    assign h_raw     = div_quot[NUM5_W-1:0];
    // stopping height saturates at the altitude range
    assign h_sat     = (|h_raw[NUM5_W-1:ALT_W]) ? HEIGHT_MAX : h_raw[ALT_W-1:0];
    assign h_coast   = {1'b0, h_sat} + (ALT_W+1)'(r_coast);
    assign h_burn    = {1'b0, h_sat} + (ALT_W+1)'(r_burn);
    assign prod5     = {prod, 2'b00} + NUM5_W'(prod);

    lbts_mul #(.W(VMAG_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    lbts_div #(.NUM_W(DIV_N), .DIV_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_fault   = r_fault;
        n_accel   = r_accel;
        n_cmd     = r_cmd;
        n_wr      = r_wr;
        n_gear    = r_gear;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        mul_start = 1'b0;
        mul_a     = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = '0;
                    n_wr    = 1'b0;
                    n_gear  = 1'b0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                // fault checks run in every flying phase before the exit test
                if (r_fault == FLT_NONE && r_phase != PH_LANDED) begin
                    if (r_thrust == '0) begin
                        n_fault = FLT_NO_THRUST;
                        n_state = S_DECIDE;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {den_t, {(DIV_N-DEN_W){1'b0}}};
                        div_den   = {{(DEN_W-MASS_W){1'b0}}, r_mass};
                        div_steps = STP_W'(DEN_W);
                        n_state   = S_TM;
                    end
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_TM: begin
                if (div_done) begin
                    if (tm <= DEN_W'(r_grav)) begin
                        n_fault = FLT_WEAK;
                    end else begin
                        n_accel = tm - DEN_W'(r_grav);
                    end
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_fault != FLT_NONE) begin
                    n_wr = 1'b1;
                end else begin
                    case (r_phase)
                        PH_HKILL: begin
                            if (r_hs <= HS_W'(r_hlim)) begin
                                n_wr    = 1'b1;
                                n_gear  = 1'b1;
                                n_phase = PH_BURN;
                            end else begin
                                mul_start = 1'b1;
                                mul_a     = r_vmag;
                                n_state   = S_MUL;
                            end
                        end
                        PH_BURN: begin
                            if (r_ts <= TS_W'(r_final)) begin
                                n_phase = PH_FINAL;
                            end else begin
                                mul_start = 1'b1;
                                mul_a     = VMAG_W'(r_ts);
                                n_state   = S_MUL;
                            end
                        end
                        PH_FINAL: begin
                            if (r_alt <= ALT_W'(r_touch)) begin
                                n_wr    = 1'b1;
                                n_phase = PH_LANDED;
                            end else if (r_thr == THR_FULL) begin
                                n_wr = 1'b1;
                                if ({1'b0, grav_mass} >= den_t) begin
                                    n_cmd = THR_FULL;
                                end else begin
                                    // hover throttle, shares the divider
                                    div_start = 1'b1;
                                    div_num   = {grav_mass, {F{1'b0}}};
                                    div_den   = den_t;
                                    div_steps = STP_W'(DIV_N);
                                    n_state   = S_SDIV;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = {prod5, {(DIV_N-NUM5_W){1'b0}}};
                    div_den   = r_accel;
                    div_steps = STP_W'(NUM5_W);
                    n_state   = S_SDIV;
                end
            end
            S_SDIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                    case (r_phase)
                        PH_HKILL: begin
                            if ({1'b0, r_alt} <= h_coast && r_thr < THR_FULL) begin
                                n_wr  = 1'b1;
                                n_cmd = THR_FULL;
                            end
                        end
                        PH_BURN: begin
                            if (h_burn < {1'b0, r_alt}) begin
                                if (r_thr != '0) begin
                                    n_wr = 1'b1;
                                end
                            end else if (r_thr < THR_FULL) begin
                                n_wr  = 1'b1;
                                n_cmd = THR_FULL;
                            end
                        end
                        default: begin
                            // final phase: quotient is below full scale here
                            n_cmd = {1'b0, div_quot[F-1:0]};
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_HKILL;
            r_fault  <= FLT_NONE;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fault <= n_fault;
            if (r_state == S_DONE && (!r_mvalid || m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_accel <= n_accel;
        r_cmd   <= n_cmd;
        r_wr    <= n_wr;
        r_gear  <= n_gear;
        if (r_state == S_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mdata <= OUT_BW'({r_fault, r_phase, r_gear, r_wr, r_cmd});
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
endmodule

// ===== tb/landing_burn_throttle_sequencer_top_tb.sv =====
// self-checking testbench of the landing burn throttle sequencer top level
`timescale 1ns / 1ps

module landing_burn_throttle_sequencer_top_tb;
    import lbts_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] FULL = 64'd1 << FRAC;
    localparam int CLK_HALF = 4;

    typedef struct packed {
        logic [16:0] thr;
        logic [30:0] alt;
        logic [19:0] ts;
        logic [20:0] vs;
        logic [19:0] hs;
        logic [23:0] mass;
    } t_sample;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  phase;
        logic        gear;
        logic        wr;
        logic [16:0] cmd;
    } t_decision;

    // section kinds of the stimulus
    typedef enum int {
        SEC_HKILL, SEC_BURN, SEC_FINAL, SEC_ANY
    } t_section;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    // vessel_mass, horizontal_speed, vertical_speed, total_speed, altitude,
    // current_throttle, zero fill
    logic [135:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    // throttle_cmd, throttle_write, gear_down, landing_phase, status_code, zero fill
    logic [23:0] m_axis_tdata;

    landing_burn_throttle_sequencer_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor copy of the registers and the landing state
    logic [63:0] thrust_q, grav_q, final_q, hlim_q, coast_q, burn_q, touch_q;
    t_phase      phase_q;
    t_fault      fault_q;

    t_sample     pending_samples[$];
    t_decision   expected_decisions[$];
    int          errors;
    int          rx_hold;      // cycles the receiver still holds off
    bit          no_idle;      // stretch with no idling on either side
    bit          took;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] stop_height(logic [63:0] v, logic [63:0] accel);
        logic [63:0] h;
        h = (64'd5 * v * v) / accel;
        return (h > 64'd2147483647) ? 64'd2147483647 : h;
    endfunction

    function automatic logic [63:0] hover_cmd(logic [63:0] mass);
        logic [63:0] num, den, q;
        num = grav_q * mass;
        den = thrust_q * 64'd1000;
        q = 0;
        if (num >= den) return FULL;
        for (int i = 0; i < FRAC; i++) begin
            num = num << 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // next throttle decision, advancing the predicted landing state
    function automatic t_decision decide_throttle(t_sample s);
        t_decision d;
        logic [63:0] mass, vmag, accel, tm, alt, thr, cmd;
        mass = (s.mass == 0) ? 64'd1 : {40'd0, s.mass};
        vmag = s.vs[20] ? (64'h200000 - {43'd0, s.vs}) : {43'd0, s.vs};
        alt = {33'd0, s.alt};
        thr = {47'd0, s.thr};
        accel = 0;
        cmd = 0;
        d = '0;
        if (fault_q == FLT_NONE && phase_q != PH_LANDED) begin
            if (thrust_q == 0) begin
                fault_q = FLT_NO_THRUST;
            end else begin
                tm = (thrust_q * 64'd1000) / mass;
                if (tm <= grav_q) fault_q = FLT_WEAK;
                else accel = tm - grav_q;
            end
        end
        if (fault_q != FLT_NONE) begin
            d.wr = 1'b1;
        end else begin
            case (phase_q)
                PH_HKILL: begin
                    if (s.hs <= hlim_q) begin
                        d.wr = 1'b1;
                        d.gear = 1'b1;
                        phase_q = PH_BURN;
                    end else if (alt <= stop_height(vmag, accel) + coast_q && thr < FULL) begin
                        d.wr = 1'b1;
                        cmd = FULL;
                    end
                end
                PH_BURN: begin
                    if (s.ts <= final_q) begin
                        phase_q = PH_FINAL;
                    end else if (stop_height({44'd0, s.ts}, accel) + burn_q < alt) begin
                        if (thr > 0) d.wr = 1'b1;
                    end else if (thr < FULL) begin
                        d.wr = 1'b1;
                        cmd = FULL;
                    end
                end
                PH_FINAL: begin
                    if (alt <= touch_q) begin
                        d.wr = 1'b1;
                        phase_q = PH_LANDED;
                    end else if (thr == FULL) begin
                        d.wr = 1'b1;
                        cmd = hover_cmd(mass);
                    end
                end
                default: ;
            endcase
        end
        d.cmd = cmd[16:0];
        d.phase = phase_q;
        d.status = fault_q;
        return d;
    endfunction

    // sender: one valid per step, next request taken from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || took) begin
            took = 1'b0;
            if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 11)) begin
                s_axis_tdata <= {3'd0, pending_samples.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || $urandom_range(99) >= 11;
        end
    end

    // acceptance on both sides; prediction made in request order
    always @(posedge i_clk) begin
        t_decision got, want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_decisions.push_back(decide_throttle(t_sample'(s_axis_tdata[132:0])));
            took = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_decision'(m_axis_tdata[22:0]);
            if (expected_decisions.size() == 0) begin
                $error("decision with nothing expected: %h", got);
                errors++;
            end else begin
                want = expected_decisions.pop_front();
                if (got.cmd !== want.cmd) begin
                    $error("throttle_cmd expected %0d actual %0d", want.cmd, got.cmd);
                    errors++;
                end
                if (got.wr !== want.wr) begin
                    $error("throttle_write expected %0d actual %0d", want.wr, got.wr);
                    errors++;
                end
                if (got.gear !== want.gear) begin
                    $error("gear_down expected %0d actual %0d", want.gear, got.gear);
                    errors++;
                end
                if (got.phase !== want.phase) begin
                    $error("landing_phase expected %0d actual %0d", want.phase, got.phase);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status_code expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // wait until every request is decided and the block has gone quiet
    task automatic drain();
        wait (pending_samples.size() == 0 && !s_axis_tvalid && expected_decisions.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRUST: thrust_q = val;
            REG_GRAV:   grav_q   = val[16:0];
            REG_FINAL:  final_q  = val[16:0];
            REG_HLIM:   hlim_q   = val[16:0];
            REG_COAST:  coast_q  = val[26:0];
            REG_BURN:   burn_q   = val[26:0];
            default:    touch_q  = val[16:0];
        endcase
    endtask

    // low end, high end or anything between
    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        int r;
        r = $urandom_range(3);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(hi, lo);
    endfunction

    // new settings; thrust kept high enough that no sample of a section faults
    task automatic reconfigure();
        drain();
        reg_write(REG_THRUST, pick(32'd1_000_000, 32'hFFFF_FFFF));
        reg_write(REG_GRAV, pick(0, 100000));
        reg_write(REG_FINAL, pick(0, 100000));
        reg_write(REG_HLIM, pick(0, 100000));
        reg_write(REG_COAST, pick(0, 100_000_000));
        reg_write(REG_BURN, pick(0, 100_000_000));
        reg_write(REG_TOUCH, pick(0, 100000));
    endtask

    // random sample that stays inside the given section
    function automatic t_sample rand_sample(t_section sec);
        t_sample s;
        logic [63:0] mmax;
        mmax = (thrust_q * 64'd1000) / (grav_q + 1);
        if (mmax > 64'hFF_FFFF) mmax = 64'hFF_FFFF;
        s.mass = (sec != SEC_ANY) ? $urandom_range(mmax[31:0], 1) : $urandom();
        s.hs = $urandom();
        s.vs = $urandom();
        s.ts = $urandom();
        s.alt = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4_000_000);
        case ($urandom_range(3))
            0: s.thr = FULL[16:0];
            1: s.thr = 0;
            2: s.thr = $urandom_range(65536);
            default: s.thr = $urandom();
        endcase
        if (sec == SEC_HKILL) s.hs = $urandom_range(20'hF_FFFF, hlim_q + 1);
        if (sec == SEC_BURN) s.ts = $urandom_range(20'hF_FFFF, final_q + 1);
        if (sec == SEC_FINAL && s.alt <= touch_q) s.alt = $urandom_range(31'h7FFF_FFFF, touch_q + 1);
        return s;
    endfunction

    initial begin
        t_sample s;
        int ending;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        errors = 0; rx_hold = 0; no_idle = 1'b0; took = 1'b0;
        thrust_q = RST_THRUST; grav_q = RST_GRAV; final_q = RST_FINAL; hlim_q = RST_HLIM;
        coast_q = RST_COAST; burn_q = RST_BURN; touch_q = RST_TOUCH;
        phase_q = PH_HKILL; fault_q = FLT_NONE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        reg_write(REG_THRUST, 32'hFFFF_FFFF);
        reg_write(REG_HLIM, 1000);

        // directed horizontal kill samples: field extremes and special cases
        s = rand_sample(SEC_HKILL);
        s.mass = 0; s.vs = 21'h10_0000; s.alt = 0; s.thr = 0;
        pending_samples.push_back(s);
        s.mass = 24'hFF_FFFF; s.vs = 21'h0F_FFFF; s.alt = 31'h7FFF_FFFF; s.thr = 17'h1_FFFF;
        pending_samples.push_back(s);
        s.hs = 20'hF_FFFF; s.ts = 20'hF_FFFF; s.thr = FULL[16:0]; s.alt = 100;
        pending_samples.push_back(s);
        s.vs = 0; s.ts = 0; s.thr = 17'h0_FFFF; s.mass = 1;
        pending_samples.push_back(s);

        // random horizontal kill, long hold-off of the receiver in the middle
        for (int b = 0; b < 2; b++) begin
            reconfigure();
            if (b == 1) rx_hold = 600;
            repeat (270) pending_samples.push_back(rand_sample(SEC_HKILL));
        end
        drain();
        s = rand_sample(SEC_ANY);
        s.mass = 1; s.hs = hlim_q[19:0];
        pending_samples.push_back(s);

        // burn phase, a stretch with no idling at all
        for (int b = 0; b < 2; b++) begin
            reconfigure();
            no_idle = (b == 0);
            repeat (270) pending_samples.push_back(rand_sample(SEC_BURN));
        end
        drain();
        no_idle = 1'b0;
        s = rand_sample(SEC_ANY);
        s.mass = 1; s.ts = final_q[19:0];
        pending_samples.push_back(s);

        // final phase, hover throttle
        for (int b = 0; b < 2; b++) begin
            reconfigure();
            repeat (270) pending_samples.push_back(rand_sample(SEC_FINAL));
        end
        drain();

        // the end of the descent: a landing, no thrust, or thrust below weight
        ending = $urandom_range(3);
        if (ending == 1) begin
            reg_write(REG_THRUST, 0);
        end else if (ending == 2) begin
            reg_write(REG_THRUST, 1);
            reg_write(REG_GRAV, 100000);
        end else begin
            s = rand_sample(SEC_ANY);
            s.mass = 1; s.alt = touch_q[30:0];
            pending_samples.push_back(s);
        end
        repeat (60) pending_samples.push_back(rand_sample(SEC_ANY));
        drain();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
